[design/sv39ptw_pkg.sv]
// Shared types and constants for the Sv39 table walker.
`timescale 1ns / 1ps

package sv39ptw_pkg;

	localparam int TABLE_PAGES_DEF = 64;
	localparam int VPN_W           = 9;
	localparam int ENTRIES         = 512;
	localparam int PPN_W           = 44;
	localparam int BASE_W          = 44;
	localparam int LOC_W           = 15;

	localparam logic [1:0] KIND_WALK  = 2'd0;
	localparam logic [1:0] KIND_MAP   = 2'd1;
	localparam logic [1:0] KIND_MEGA  = 2'd2;
	localparam logic [1:0] KIND_PROBE = 2'd3;

	localparam logic [1:0] LEVEL_TOP  = 2'd2;
	localparam logic [1:0] LEVEL_MID  = 2'd1;
	localparam logic [1:0] LEVEL_LEAF = 2'd0;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_VA_RANGE   = 3'd1,
		ST_NOT_MAPPED = 3'd2,
		ST_NO_FREE    = 3'd3,
		ST_MISALIGNED = 3'd4,
		ST_ALREADY    = 3'd5,
		ST_BAD_PTR    = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_READ,
		S_EVAL,
		S_SWEEP,
		S_LINK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic en;
		logic we;
	} mem_cmd_t;

	typedef struct packed {
		status_t           status;
		logic [63:0]       value;
		logic [LOC_W-1:0]  loc;
	} result_t;

endpackage

[design/sv39ptw_store.sv]
// Single-port table store with registered read data.
`timescale 1ns / 1ps

module sv39ptw_store #(
	parameter int DEPTH = sv39ptw_pkg::TABLE_PAGES_DEF * sv39ptw_pkg::ENTRIES,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  sv39ptw_pkg::mem_cmd_t cmd,
	input  logic [AW-1:0]         addr,
	input  logic [63:0]           wdata,
	output logic [63:0]           rdata
);

	logic [63:0] mem_q [DEPTH];
	logic [63:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			if (cmd.we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

[design/sv39ptw_ctrl.sv]
// Walk sequencer: clear pass, level descent, allocation and leaf update.
`timescale 1ns / 1ps

module sv39ptw_ctrl #(
	parameter int TABLE_PAGES = sv39ptw_pkg::TABLE_PAGES_DEF,
	parameter int PW          = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1,
	parameter int AW          = PW + sv39ptw_pkg::VPN_W
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic [1:0]                         kind,
	input  logic [63:0]                        virt_addr,
	input  logic [55:0]                        phys_addr,
	input  logic [9:0]                         permissions,
	input  logic                               allocate,
	input  logic [sv39ptw_pkg::BASE_W-1:0]     base_ppn,
	output logic                               res_valid,
	input  logic                               res_ready,
	output sv39ptw_pkg::result_t               res,
	output sv39ptw_pkg::mem_cmd_t              mem_cmd,
	output logic [AW-1:0]                      mem_addr,
	output logic [63:0]                        mem_wdata,
	input  logic [63:0]                        mem_rdata
);

	localparam int DEPTH = TABLE_PAGES * sv39ptw_pkg::ENTRIES;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [PW:0] PAGES_N = (PW + 1)'(TABLE_PAGES);
	localparam logic [sv39ptw_pkg::PPN_W-1:0] PAGES_PPN = sv39ptw_pkg::PPN_W'(TABLE_PAGES);
	localparam logic [sv39ptw_pkg::VPN_W-1:0] LAST_ENTRY = sv39ptw_pkg::VPN_W'(sv39ptw_pkg::ENTRIES - 1);

	sv39ptw_pkg::state_t state_q, state_d;

	logic [1:0]                  kind_q;
	logic [63:0]                 va_q;
	logic [55:0]                 pa_q;
	logic [9:0]                  perm_q;
	logic                        alloc_q;
	logic [1:0]                  lvl_q;
	logic [PW-1:0]               page_q;
	logic [AW-1:0]               loc_q;
	logic [PW:0]                 next_free_q;
	logic [PW:0]                 hw_q;
	logic [AW-1:0]               clr_q;
	logic [sv39ptw_pkg::VPN_W-1:0] sweep_q;
	sv39ptw_pkg::result_t        res_q;

	logic [sv39ptw_pkg::VPN_W-1:0] vpn;
	logic [AW-1:0]               read_addr;
	logic                        is_map;
	logic                        may_alloc;
	logic [1:0]                  last_lvl;
	logic                        misaligned;
	logic [sv39ptw_pkg::PPN_W-1:0] off;
	logic [sv39ptw_pkg::PPN_W-1:0] new_ppn;
	logic [63:0]                 ptr_val;
	logic [63:0]                 leaf_val;
	logic [PW-1:0]               wr_page;

	logic                        fin;
	sv39ptw_pkg::status_t        fin_status;
	logic [63:0]                 fin_value;
	logic                        fin_loc_zero;
	logic                        step_down;
	logic [PW-1:0]               down_page;
	logic                        bump;
	logic                        hw_touch;

	always_comb begin
		case (lvl_q)
			sv39ptw_pkg::LEVEL_TOP: vpn = va_q[38:30];
			sv39ptw_pkg::LEVEL_MID: vpn = va_q[29:21];
			default:                vpn = va_q[20:12];
		endcase
	end

	assign read_addr = {page_q, vpn};
	assign is_map    = (kind_q == sv39ptw_pkg::KIND_MAP) || (kind_q == sv39ptw_pkg::KIND_MEGA);
	assign may_alloc = is_map || ((kind_q == sv39ptw_pkg::KIND_WALK) && alloc_q);
	assign last_lvl  = (kind_q == sv39ptw_pkg::KIND_MEGA) ? sv39ptw_pkg::LEVEL_MID
	                                                      : sv39ptw_pkg::LEVEL_LEAF;
	assign misaligned = (kind_q == sv39ptw_pkg::KIND_MEGA)
		? ((|va_q[20:0]) || (|pa_q[20:0]))
		: ((|va_q[11:0]) || (|pa_q[11:0]));

	assign off      = mem_rdata[53:10] - base_ppn;
	assign new_ppn  = base_ppn + sv39ptw_pkg::PPN_W'(next_free_q);
	assign ptr_val  = {10'b0, new_ppn, 10'b0} | 64'd1;
	assign leaf_val = {10'b0, pa_q[55:12], 10'b0} | {54'b0, perm_q} | 64'd1;
	assign wr_page  = loc_q[AW-1:sv39ptw_pkg::VPN_W];

	always_comb begin
		state_d      = state_q;
		mem_cmd      = '0;
		mem_addr     = read_addr;
		mem_wdata    = '0;
		fin          = 1'b0;
		fin_status   = sv39ptw_pkg::ST_OK;
		fin_value    = '0;
		fin_loc_zero = 1'b0;
		step_down    = 1'b0;
		down_page    = off[PW-1:0];
		bump         = 1'b0;
		hw_touch     = 1'b0;
		case (state_q)
			sv39ptw_pkg::S_CLEAR: begin
				mem_cmd  = '{en: 1'b1, we: 1'b1};
				mem_addr = clr_q;
				if (clr_q == LAST_ADDR) begin
					state_d = sv39ptw_pkg::S_IDLE;
				end
			end
			sv39ptw_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = sv39ptw_pkg::S_START;
				end
			end
			sv39ptw_pkg::S_START: begin
				if (is_map && misaligned) begin
					fin          = 1'b1;
					fin_status   = sv39ptw_pkg::ST_MISALIGNED;
					fin_loc_zero = 1'b1;
				end else if (|va_q[63:39]) begin
					fin          = 1'b1;
					fin_status   = sv39ptw_pkg::ST_VA_RANGE;
					fin_loc_zero = 1'b1;
				end else begin
					state_d = sv39ptw_pkg::S_READ;
				end
			end
			sv39ptw_pkg::S_READ: begin
				mem_cmd = '{en: 1'b1, we: 1'b0};
				state_d = sv39ptw_pkg::S_EVAL;
			end
			sv39ptw_pkg::S_EVAL: begin
				mem_addr  = loc_q;
				fin_value = mem_rdata;
				if (lvl_q != last_lvl) begin
					// descend through a table pointer
					if (mem_rdata[0]) begin
						if (|mem_rdata[3:1]) begin
							fin        = 1'b1;
							fin_status = sv39ptw_pkg::ST_ALREADY;
						end else if (off >= PAGES_PPN) begin
							fin        = 1'b1;
							fin_status = sv39ptw_pkg::ST_BAD_PTR;
						end else begin
							step_down = 1'b1;
							state_d   = sv39ptw_pkg::S_READ;
						end
					end else if (!may_alloc) begin
						fin        = 1'b1;
						fin_status = sv39ptw_pkg::ST_NOT_MAPPED;
					end else if (next_free_q >= PAGES_N) begin
						fin        = 1'b1;
						fin_status = sv39ptw_pkg::ST_NO_FREE;
					end else if (next_free_q < hw_q) begin
						// page may hold stale writes: zero it first
						state_d = sv39ptw_pkg::S_SWEEP;
					end else begin
						mem_cmd   = '{en: 1'b1, we: 1'b1};
						mem_wdata = ptr_val;
						hw_touch  = 1'b1;
						step_down = 1'b1;
						down_page = next_free_q[PW-1:0];
						bump      = 1'b1;
						state_d   = sv39ptw_pkg::S_READ;
					end
				end else begin
					fin = 1'b1;
					if (is_map) begin
						if (mem_rdata[0]) begin
							fin_status = sv39ptw_pkg::ST_ALREADY;
						end else begin
							mem_cmd   = '{en: 1'b1, we: 1'b1};
							mem_wdata = leaf_val;
							hw_touch  = 1'b1;
							fin_value = leaf_val;
						end
					end
				end
			end
			sv39ptw_pkg::S_SWEEP: begin
				mem_cmd  = '{en: 1'b1, we: 1'b1};
				mem_addr = {next_free_q[PW-1:0], sweep_q};
				if (sweep_q == LAST_ENTRY) begin
					state_d = sv39ptw_pkg::S_LINK;
				end
			end
			sv39ptw_pkg::S_LINK: begin
				mem_cmd   = '{en: 1'b1, we: 1'b1};
				mem_addr  = loc_q;
				mem_wdata = ptr_val;
				hw_touch  = 1'b1;
				step_down = 1'b1;
				down_page = next_free_q[PW-1:0];
				bump      = 1'b1;
				state_d   = sv39ptw_pkg::S_READ;
			end
			sv39ptw_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = sv39ptw_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sv39ptw_pkg::S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = sv39ptw_pkg::S_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sv39ptw_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// allocation and sweep bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= (PW + 1)'(1);
			hw_q        <= '0;
			clr_q       <= '0;
			sweep_q     <= '0;
		end else begin
			if (state_q == sv39ptw_pkg::S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == sv39ptw_pkg::S_SWEEP) begin
				sweep_q <= sweep_q + sv39ptw_pkg::VPN_W'(1);
			end
			if (bump) begin
				next_free_q <= next_free_q + (PW + 1)'(1);
			end
			if (hw_touch && ({1'b0, wr_page} >= hw_q)) begin
				hw_q <= {1'b0, wr_page} + (PW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sv39ptw_pkg::S_IDLE && req_valid) begin
			kind_q  <= kind;
			va_q    <= virt_addr;
			pa_q    <= phys_addr;
			perm_q  <= permissions;
			alloc_q <= allocate;
		end
		if (state_q == sv39ptw_pkg::S_START) begin
			lvl_q  <= sv39ptw_pkg::LEVEL_TOP;
			page_q <= '0;
		end
		if (state_q == sv39ptw_pkg::S_READ) begin
			loc_q <= read_addr;
		end
		if (step_down) begin
			page_q <= down_page;
			lvl_q  <= lvl_q - 2'd1;
		end
		if (fin) begin
			res_q.status <= fin_status;
			res_q.value  <= fin_value;
			res_q.loc    <= fin_loc_zero ? '0 : sv39ptw_pkg::LOC_W'(loc_q);
		end
	end

	assign req_ready = (state_q == sv39ptw_pkg::S_IDLE);
	assign res_valid = (state_q == sv39ptw_pkg::S_DONE);
	assign res       = res_q;

endmodule

[design/sv39_page_table_walk_map_core.sv]
// Top level of the Sv39 page-table walker and mapper.
`timescale 1ns / 1ps

// Sv39 page-table walk and map engine over an on-chip store of TABLE_PAGES table pages of
// 512 entries each; page 0 is the root. A request beat (kind, virt_addr, phys_addr,
// permissions, allocate) yields exactly one result beat (status, entry_value,
// entry_location). Kind 0 walks to the level-0 entry and allocates missing tables when
// allocate is set, kind 1 maps a 4 KiB leaf at level 0, kind 2 maps a 2 MiB leaf at
// level 1, kind 3 walks without allocating. Requests run one at a time against a single
// port store with registered read data: each level takes a read state and an evaluate
// state. Allocating a page adds no sweep when that page has never been written; a page
// that has seen stray writes (a pointer that targets a page beyond the bump counter after
// table_base_ppn changed) is zeroed first. After reset the store is cleared, one entry per
// cycle, TABLE_PAGES*512 entries (32768 at the default size) while in_ready stays low;
// cfg_wr_en writes table_base_ppn at any time, but change it only while the block is idle.
// The result sits in an output register, so the next request beat is taken while an
// earlier result still waits on out_ready.

module sv39_page_table_walk_map_core #(
	parameter int TABLE_PAGES = sv39ptw_pkg::TABLE_PAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_wr_en,
	input  logic [sv39ptw_pkg::BASE_W-1:0] cfg_wr_data,
	// request channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     kind,
	input  logic [63:0]                    virt_addr,
	input  logic [55:0]                    phys_addr,
	input  logic [9:0]                     permissions,
	input  logic                           allocate,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     status,
	output logic [63:0]                    entry_value,
	output logic [sv39ptw_pkg::LOC_W-1:0]  entry_location
);

	localparam int PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	localparam int AW    = PW + sv39ptw_pkg::VPN_W;
	localparam int DEPTH = TABLE_PAGES * sv39ptw_pkg::ENTRIES;

	logic [sv39ptw_pkg::BASE_W-1:0] base_q;
	logic                           out_valid_q;
	sv39ptw_pkg::result_t           out_q;

	sv39ptw_pkg::result_t           res;
	logic                           res_valid;
	logic                           res_ready;
	sv39ptw_pkg::mem_cmd_t          mem_cmd;
	logic [AW-1:0]                  mem_addr;
	logic [63:0]                    mem_wdata;
	logic [63:0]                    mem_rdata;

	// table base register: written directly, no handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	sv39ptw_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.cmd   (mem_cmd),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	sv39ptw_ctrl #(
		.TABLE_PAGES (TABLE_PAGES),
		.PW          (PW),
		.AW          (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (in_valid),
		.req_ready   (in_ready),
		.kind        (kind),
		.virt_addr   (virt_addr),
		.phys_addr   (phys_addr),
		.permissions (permissions),
		.allocate    (allocate),
		.base_ppn    (base_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_cmd     (mem_cmd),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata)
	);

	// output register: take a new result when empty or when the held beat leaves
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign entry_value    = out_q.value;
	assign entry_location = out_q.loc;

endmodule

[design/sv39ptw_checker.sv]
// Port-level checks for the Sv39 table walker, bound to the top level.
`timescale 1ns / 1ps

module sv39ptw_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [2:0]                    status,
	input logic [63:0]                   entry_value,
	input logic [sv39ptw_pkg::LOC_W-1:0] entry_location
);

	// a stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_value)
			&& $stable(entry_location))
		else $error("result beat changed while stalled");

	// one request in flight: no second accept right after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	// rejected requests report no entry
	a_reject_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sv39ptw_pkg::ST_VA_RANGE || status == sv39ptw_pkg::ST_MISALIGNED)
			|-> entry_value == '0 && entry_location == '0)
		else $error("rejected request reports an entry");

	// missing-table failures stop on an invalid entry
	a_stop_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sv39ptw_pkg::ST_NOT_MAPPED || status == sv39ptw_pkg::ST_NO_FREE)
			|-> !entry_value[0])
		else $error("descent failure on a valid entry");

	// leaf or bad pointer failures stop on a valid entry
	a_stop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sv39ptw_pkg::ST_ALREADY || status == sv39ptw_pkg::ST_BAD_PTR)
			|-> entry_value[0])
		else $error("occupied or pointer failure on an invalid entry");

endmodule

bind sv39_page_table_walk_map_core sv39ptw_checker u_sv39ptw_checker (.*);

[verif/tb_sv39_page_table_walk_map_core.sv]
// Self-checking testbench for the Sv39 page-table walk and map core.
`timescale 1ns / 1ps

module tb_sv39_page_table_walk_map_core;

	// Store geometry and timing knobs.
	localparam int          STORE_DEPTH    = sv39ptw_pkg::TABLE_PAGES_DEF * sv39ptw_pkg::ENTRIES;
	localparam logic [63:0] VA_SPAN        = 64'h80_0000_0000;  // first address past Sv39
	localparam int          HOLD_OFF_LEN   = 400;   // long receiver hold-off, in cycles
	localparam int          SETTLE_CYCLES  = 16;    // quiet cycles before a register write
	localparam int          DRAIN_CYCLES   = 40;    // quiet cycles after the last result
	localparam int          PHASE_ITEMS    = 150;
	localparam int          NUM_PHASES     = 5;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] va;
		logic [55:0] pa;
		logic [9:0]  perm;
		logic        alloc;
	} request_t;

	// One line of the directed plan: either a register write or a request beat,
	// the latter optionally carrying a hand-computed result.
	typedef struct packed {
		logic                           is_cfg;
		logic [sv39ptw_pkg::BASE_W-1:0] base;
		request_t                       rq;
		logic                           typed;
		sv39ptw_pkg::result_t           typed_res;
	} plan_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [sv39ptw_pkg::BASE_W-1:0] cfg_wr_data;
	logic                           in_valid;
	logic                           in_ready;
	logic [1:0]                     kind;
	logic [63:0]                    virt_addr;
	logic [55:0]                    phys_addr;
	logic [9:0]                     permissions;
	logic                           allocate;
	logic                           out_valid;
	logic                           out_ready;
	logic [2:0]                     status;
	logic [63:0]                    entry_value;
	logic [sv39ptw_pkg::LOC_W-1:0]  entry_location;

	// Shadow copy of the table store and allocator, updated at each accepted beat.
	logic [63:0]                    store_mem [0:STORE_DEPTH-1];
	int unsigned                    bump_page;
	logic [sv39ptw_pkg::BASE_W-1:0] table_base;

	sv39ptw_pkg::result_t           walk_results_due [$];
	plan_row_t                      plan [$];
	int                             mismatch_count;
	int                             send_idle_pct;
	int                             ready_stall_pct;
	logic                           hold_off_pending;

	sv39_page_table_walk_map_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.virt_addr      (virt_addr),
		.phys_addr      (phys_addr),
		.permissions    (permissions),
		.allocate       (allocate),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.entry_value    (entry_value),
		.entry_location (entry_location)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the handshake locks up. The slowest legal run (every allocation
	// paying a page sweep, every beat waiting out the longest stall) stays well below this.
	initial begin
		#8_000_000;
		$display("sv39_page_table_walk_map_core regression: fail");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Descend one level from page; loc tracks the entry that was looked at. Missing
	// tables are taken from the bump counter when grow is set.
	function automatic sv39ptw_pkg::status_t descend_level(inout int unsigned page,
			input logic [63:0] va, input int lvl, input bit grow,
			output int unsigned loc);
		logic [63:0]                   pte;
		logic [sv39ptw_pkg::PPN_W-1:0] off;
		logic [sv39ptw_pkg::PPN_W-1:0] ppn;
		int unsigned                   np;
		loc = page * sv39ptw_pkg::ENTRIES + va[12 + 9 * lvl +: 9];
		pte = store_mem[loc];
		if (pte[0]) begin
			if (pte[3:1] != 3'b000)
				return sv39ptw_pkg::ST_ALREADY;
			off = pte[53:10] - table_base;
			if (off >= sv39ptw_pkg::TABLE_PAGES_DEF)
				return sv39ptw_pkg::ST_BAD_PTR;
			page = 32'(off);
			return sv39ptw_pkg::ST_OK;
		end
		if (!grow)
			return sv39ptw_pkg::ST_NOT_MAPPED;
		if (bump_page >= sv39ptw_pkg::TABLE_PAGES_DEF)
			return sv39ptw_pkg::ST_NO_FREE;
		np = bump_page;
		bump_page++;
		for (int i = 0; i < sv39ptw_pkg::ENTRIES; i++)
			store_mem[np * sv39ptw_pkg::ENTRIES + i] = '0;
		ppn = table_base + sv39ptw_pkg::PPN_W'(np);
		store_mem[loc] = {10'd0, ppn, 9'd0, 1'b1};
		page = np;
		return sv39ptw_pkg::ST_OK;
	endfunction

	// Work out the result beat of one request and apply its side effects to the shadow.
	function automatic sv39ptw_pkg::result_t compute_walk_result(input request_t rq);
		sv39ptw_pkg::result_t r;
		logic [63:0]          amask;
		int unsigned          page;
		int unsigned          loc;
		int                   lvl;
		int                   last;
		bit                   have_loc;
		sv39ptw_pkg::status_t st;
		st       = sv39ptw_pkg::ST_OK;
		page     = 0;
		loc      = 0;
		have_loc = 1'b0;
		if (rq.op == sv39ptw_pkg::KIND_MAP || rq.op == sv39ptw_pkg::KIND_MEGA) begin
			amask = (rq.op == sv39ptw_pkg::KIND_MAP) ? 64'hFFF : 64'h1F_FFFF;
			if ((rq.va & amask) != 0 || ({8'd0, rq.pa} & amask) != 0)
				st = sv39ptw_pkg::ST_MISALIGNED;
			else if (rq.va >= VA_SPAN)
				st = sv39ptw_pkg::ST_VA_RANGE;
			else begin
				last     = (rq.op == sv39ptw_pkg::KIND_MAP) ? 0 : 1;
				have_loc = 1'b1;
				for (lvl = 2; lvl > last && st == sv39ptw_pkg::ST_OK; lvl--)
					st = descend_level(page, rq.va, lvl, 1'b1, loc);
				if (st == sv39ptw_pkg::ST_OK) begin
					loc = page * sv39ptw_pkg::ENTRIES + rq.va[12 + 9 * last +: 9];
					if (store_mem[loc][0])
						st = sv39ptw_pkg::ST_ALREADY;
					else
						store_mem[loc] = {10'd0, rq.pa[55:12], rq.perm} | 64'd1;
				end
			end
		end else begin
			if (rq.va >= VA_SPAN)
				st = sv39ptw_pkg::ST_VA_RANGE;
			else begin
				have_loc = 1'b1;
				for (lvl = 2; lvl > 0 && st == sv39ptw_pkg::ST_OK; lvl--)
					st = descend_level(page, rq.va, lvl,
						(rq.op == sv39ptw_pkg::KIND_WALK) && rq.alloc, loc);
				if (st == sv39ptw_pkg::ST_OK)
					loc = page * sv39ptw_pkg::ENTRIES + rq.va[20:12];
			end
		end
		r.status = st;
		r.value  = have_loc ? store_mem[loc] : 64'd0;
		r.loc    = have_loc ? loc[sv39ptw_pkg::LOC_W-1:0] : '0;
		return r;
	endfunction

	function automatic plan_row_t plan_req(input logic [1:0] op, input logic [63:0] va,
			input logic [55:0] pa, input logic [9:0] perm, input logic alloc);
		plan_row_t row;
		row          = '0;
		row.rq.op    = op;
		row.rq.va    = va;
		row.rq.pa    = pa;
		row.rq.perm  = perm;
		row.rq.alloc = alloc;
		return row;
	endfunction

	function automatic plan_row_t plan_chk(input logic [1:0] op, input logic [63:0] va,
			input logic [55:0] pa, input logic [9:0] perm, input logic alloc,
			input sv39ptw_pkg::status_t st, input logic [63:0] val,
			input logic [sv39ptw_pkg::LOC_W-1:0] loc);
		plan_row_t row;
		row                  = plan_req(op, va, pa, perm, alloc);
		row.typed            = 1'b1;
		row.typed_res.status = st;
		row.typed_res.value  = val;
		row.typed_res.loc    = loc;
		return row;
	endfunction

	function automatic plan_row_t plan_base(input logic [sv39ptw_pkg::BASE_W-1:0] base);
		plan_row_t row;
		row        = '0;
		row.is_cfg = 1'b1;
		row.base   = base;
		return row;
	endfunction

	// Most beats walk a small pool of table prefixes so that later beats land on tables
	// that earlier ones built; the rest is noise over the whole field ranges.
	function automatic request_t random_request();
		request_t    q;
		logic [63:0] r;
		logic [8:0]  vpn2;
		logic [8:0]  vpn1;
		logic [8:0]  vpn0;
		int          pick;
		case ($urandom_range(4))
			0: vpn2 = 9'd0;
			1: vpn2 = 9'd1;
			2: vpn2 = 9'd2;
			3: vpn2 = 9'd7;
			default: vpn2 = 9'h1FF;
		endcase
		case ($urandom_range(3))
			0: vpn1 = 9'd0;
			1: vpn1 = 9'd1;
			2: vpn1 = 9'd5;
			default: vpn1 = 9'h1FF;
		endcase
		vpn0    = $urandom_range(1) ? 9'($urandom_range(3)) : 9'($urandom_range(511));
		r       = {$urandom, $urandom};
		q.pa    = r[55:0];
		q.perm  = 10'($urandom_range(1023));
		q.alloc = 1'($urandom_range(1));
		if ($urandom_range(99) < 85) begin
			q.va = {25'd0, vpn2, vpn1, vpn0, 12'd0};
			pick = $urandom_range(99);
			if (pick < 35) begin
				q.op         = sv39ptw_pkg::KIND_WALK;
				q.va[11:0]   = 12'($urandom);
			end else if (pick < 65) begin
				q.op         = sv39ptw_pkg::KIND_MAP;
				q.pa[11:0]   = '0;
			end else if (pick < 85) begin
				q.op         = sv39ptw_pkg::KIND_MEGA;
				q.va[20:12]  = '0;
				q.pa[20:0]   = '0;
			end else begin
				q.op         = sv39ptw_pkg::KIND_PROBE;
				q.va[11:0]   = 12'($urandom);
			end
		end else begin
			q.op = 2'($urandom_range(3));
			q.va = {$urandom, $urandom};
			// keep half of the noise inside Sv39 so it builds fresh tables
			if ($urandom_range(1))
				q.va[63:39] = '0;
			if ($urandom_range(1)) begin
				q.va[11:0] = '0;
				q.pa[11:0] = '0;
				if (q.op == sv39ptw_pkg::KIND_MEGA) begin
					q.va[20:0] = '0;
					q.pa[20:0] = '0;
				end
			end
		end
		return q;
	endfunction

	// Offer one request beat; hold it until taken, then log its expected result.
	task automatic send_request(input request_t rq, input logic typed,
			input sv39ptw_pkg::result_t typed_res);
		sv39ptw_pkg::result_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= rq.op;
		virt_addr   <= rq.va;
		phys_addr   <= rq.pa;
		permissions <= rq.perm;
		allocate    <= rq.alloc;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = compute_walk_result(rq);
		walk_results_due.push_back(typed ? typed_res : predicted);
	endtask

	// Write the base register once nothing is in flight.
	task automatic write_table_base(input logic [sv39ptw_pkg::BASE_W-1:0] base);
		@(negedge clk);
		in_valid <= 1'b0;
		while (walk_results_due.size() != 0 || !in_ready)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= base;
		@(posedge clk);
		table_base = base;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Result side: random stalls per phase, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_LEN) @(negedge clk);
			end
			out_ready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	// Compare every result beat against the oldest expectation.
	always @(posedge clk) begin
		sv39ptw_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (walk_results_due.size() == 0)
				report_mismatch("unexpected result beat, status", status, 0);
			else begin
				want = walk_results_due.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (entry_value !== want.value)
					report_mismatch("entry_value", entry_value, want.value);
				if (entry_location !== want.loc)
					report_mismatch("entry_location", entry_location, want.loc);
			end
		end
	end

	initial begin
		sv39ptw_pkg::result_t none;
		request_t             rq;
		logic [63:0]          rbase;
		none             = '0;
		mismatch_count   = 0;
		send_idle_pct    = 0;
		ready_stall_pct  = 0;
		hold_off_pending = 1'b0;
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = '0;
		in_valid         = 1'b0;
		kind             = sv39ptw_pkg::KIND_WALK;
		virt_addr        = '0;
		phys_addr        = '0;
		permissions      = '0;
		allocate         = 1'b0;

		// Shadow matches the state right after reset: empty store, root is page 0.
		for (int i = 0; i < STORE_DEPTH; i++)
			store_mem[i] = '0;
		bump_page  = 1;
		table_base = '0;

		// Directed plan, starting on an empty store with base 0.
		plan.push_back(plan_base(44'd0));
		// empty root: walk without allocation stops at the root entry
		plan.push_back(plan_chk(sv39ptw_pkg::KIND_WALK, 64'd0, 56'd0, 10'd0, 1'b0,
			sv39ptw_pkg::ST_NOT_MAPPED, 64'd0, 15'd0));
		// address range, on walks and on both map kinds
		plan.push_back(plan_chk(sv39ptw_pkg::KIND_WALK, VA_SPAN, 56'd0, 10'd0, 1'b0,
			sv39ptw_pkg::ST_VA_RANGE, 64'd0, 15'd0));
		plan.push_back(plan_chk(sv39ptw_pkg::KIND_WALK, '1, '1, '1, 1'b1,
			sv39ptw_pkg::ST_VA_RANGE, 64'd0, 15'd0));
		// misaligned virtual or physical address, checked before the range
		plan.push_back(plan_chk(sv39ptw_pkg::KIND_MAP, 64'h1001, 56'd0, 10'd0, 1'b0,
			sv39ptw_pkg::ST_MISALIGNED, 64'd0, 15'd0));
		plan.push_back(plan_chk(sv39ptw_pkg::KIND_MAP, 64'd0, 56'hFFF, 10'd0, 1'b0,
			sv39ptw_pkg::ST_MISALIGNED, 64'd0, 15'd0));
		plan.push_back(plan_chk(sv39ptw_pkg::KIND_MEGA, 64'h1000, 56'd0, 10'd0, 1'b0,
			sv39ptw_pkg::ST_MISALIGNED, 64'd0, 15'd0));
		plan.push_back(plan_chk(sv39ptw_pkg::KIND_MEGA, VA_SPAN, 56'd0, 10'd0, 1'b0,
			sv39ptw_pkg::ST_VA_RANGE, 64'd0, 15'd0));
		plan.push_back(plan_chk(sv39ptw_pkg::KIND_MAP, 64'h8000_0000_0000_0000, 56'd0,
			10'd0, 1'b0, sv39ptw_pkg::ST_VA_RANGE, 64'd0, 15'd0));
		// unused kind never allocates, even with allocate set
		plan.push_back(plan_chk(sv39ptw_pkg::KIND_PROBE, 64'd0, 56'd0, 10'd0, 1'b1,
			sv39ptw_pkg::ST_NOT_MAPPED, 64'd0, 15'd0));
		// allocating walk builds pages 1 and 2 and lands on an invalid leaf
		plan.push_back(plan_chk(sv39ptw_pkg::KIND_WALK, 64'd0, 56'd0, 10'd0, 1'b1,
			sv39ptw_pkg::ST_OK, 64'd0, 15'd1024));
		// widest physical address with every flag bit
		plan.push_back(plan_chk(sv39ptw_pkg::KIND_MAP, 64'd0, 56'hFF_FFFF_FFFF_F000,
			10'h3FF, 1'b0, sv39ptw_pkg::ST_OK, 64'h003F_FFFF_FFFF_FFFF, 15'd1024));
		// occupied target leaves the entry alone
		plan.push_back(plan_chk(sv39ptw_pkg::KIND_MAP, 64'd0, 56'h1000, 10'h001, 1'b1,
			sv39ptw_pkg::ST_ALREADY, 64'h003F_FFFF_FFFF_FFFF, 15'd1024));
		plan.push_back(plan_req(sv39ptw_pkg::KIND_WALK, 64'd0, 56'd0, 10'd0, 1'b0));
		// megapage leaf at level 1, then walks and maps that run into it
		plan.push_back(plan_req(sv39ptw_pkg::KIND_MEGA, 64'h20_0000, 56'h20_0000, 10'h00E,
			1'b0));
		plan.push_back(plan_req(sv39ptw_pkg::KIND_WALK, 64'h20_0000, 56'd0, 10'd0, 1'b1));
		plan.push_back(plan_req(sv39ptw_pkg::KIND_MEGA, 64'd0, 56'h40_0000, 10'h002, 1'b0));
		// top of the address range
		plan.push_back(plan_req(sv39ptw_pkg::KIND_WALK, 64'h7F_FFFF_FFFF, 56'd0, 10'd0,
			1'b1));
		plan.push_back(plan_req(sv39ptw_pkg::KIND_MAP, 64'h7F_FFFF_F000, 56'd0, 10'd0,
			1'b0));
		plan.push_back(plan_req(sv39ptw_pkg::KIND_WALK, 64'h4000_0000, 56'd0, 10'd0, 1'b0));
		plan.push_back(plan_req(sv39ptw_pkg::KIND_PROBE, 64'h8000_0000, 56'd0, 10'd0,
			1'b1));
		// maps allocate regardless of the allocate field
		plan.push_back(plan_req(sv39ptw_pkg::KIND_MAP, 64'h8000_0000, 56'h12_3456_7000,
			10'h0C6, 1'b0));
		// base 1 folds the root's first pointer back onto the root, so a megapage map
		// plants a leaf in the root and a walk then meets a leaf at level 2
		plan.push_back(plan_base(44'd1));
		plan.push_back(plan_req(sv39ptw_pkg::KIND_MEGA, 64'hA0_0000, 56'hA0_0000, 10'h002,
			1'b0));
		plan.push_back(plan_req(sv39ptw_pkg::KIND_WALK, 64'h1_4000_0000, 56'd0, 10'd0,
			1'b0));
		// pointer outside the store
		plan.push_back(plan_base(44'd1000));
		plan.push_back(plan_chk(sv39ptw_pkg::KIND_WALK, 64'd0, 56'd0, 10'd0, 1'b1,
			sv39ptw_pkg::ST_BAD_PTR, 64'h401, 15'd0));
		// largest base: new pointers wrap around the PPN space
		plan.push_back(plan_base('1));
		plan.push_back(plan_req(sv39ptw_pkg::KIND_WALK, 64'h1_C000_0000, 56'd0, 10'd0,
			1'b1));

		// Hold reset, then release it away from the clock edge.
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_table_base(plan[i].base);
			else
				send_request(plan[i].rq, plan[i].typed, plan[i].typed_res);
		end

		// Random phases: no idling, sender idle, receiver stalling, both, then pressure.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					send_idle_pct = 0;  ready_stall_pct = 0;  rbase = 64'd0;
				end
				1: begin
					send_idle_pct = 64; ready_stall_pct = 0;  rbase = 64'd0;
				end
				2: begin
					send_idle_pct = 0;  ready_stall_pct = 64; rbase = '1;
				end
				3: begin
					send_idle_pct = 35; ready_stall_pct = 35; rbase = {$urandom, $urandom};
				end
				default: begin
					send_idle_pct = 0;  ready_stall_pct = 0;  rbase = 64'd0;
				end
			endcase
			write_table_base(rbase[sv39ptw_pkg::BASE_W-1:0]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// in the last phase, stop the receiver for a long stretch while
				// request beats keep coming, so the core backs up into its input
				if (p == NUM_PHASES - 1 && n == 10)
					hold_off_pending = 1'b1;
				rq = random_request();
				send_request(rq, 1'b0, none);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (walk_results_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("sv39_page_table_walk_map_core regression: pass");
		else
			$display("sv39_page_table_walk_map_core regression: fail");
		$finish;
	end

endmodule
